### sv/hnsa_pkg.sv
// ----------------------------------------------------------------------------
// hnsa_pkg
// Shared types, widths and register codes for the perspective warp address
// generator.
// ----------------------------------------------------------------------------
package hnsa_pkg;

    // frame and field sizes
    localparam int SRC_WIDTH  = 1024;
    localparam int SRC_HEIGHT = 1024;
    localparam int PIX_W      = 10;
    localparam int SRC_MAX    = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int SRC_LOG    = $clog2(SRC_MAX);
    localparam int QBITS      = (SRC_LOG > PIX_W) ? SRC_LOG : PIX_W;

    // coefficient and datapath widths
    localparam int COEF_W    = 48;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int N_W       = SUM_W + 2;
    localparam int REM_W     = N_W + QBITS + 1;

    localparam logic [COEF_W-1:0] ONE_Q32 = COEF_W'(64'h1_0000_0000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_PER_COL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_PER_ROW = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_PER_COL = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_PER_ROW = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P_PER_COL = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_P_PER_ROW = 8'd7;

    typedef struct packed {
        logic [PIX_W-1:0] dest_col;
        logic [PIX_W-1:0] dest_row;
    } hnsa_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] src_col;
        logic [PIX_W-1:0] src_row;
        logic             inside_res;
    } hnsa_out_t;

    typedef logic signed [COEF_W-1:0] hnsa_coef_t;

    typedef struct packed {
        hnsa_coef_t x_per_col;
        hnsa_coef_t x_per_row;
        hnsa_coef_t x_offset;
        hnsa_coef_t y_per_col;
        hnsa_coef_t y_per_row;
        hnsa_coef_t y_offset;
        hnsa_coef_t p_per_col;
        hnsa_coef_t p_per_row;
    } hnsa_coefs_t;

    // projected numerators and divisor
    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } hnsa_xyz_t;

    // per-item division state
    typedef struct packed {
        logic [REM_W-1:0] rem_c;
        logic [REM_W-1:0] rem_r;
        logic [REM_W-1:0] dsor;
        logic [QBITS-1:0] q_c;
        logic [QBITS-1:0] q_r;
        logic             ok_c;
        logic             ok_r;
    } hnsa_div_t;

endpackage

### sv/hnsa_mac.sv
// ----------------------------------------------------------------------------
// hnsa_mac
// Two-stage multiply and sum: products of coefficients and destination
// coordinates, then the three projected sums x, y and z.
// ----------------------------------------------------------------------------
module hnsa_mac
    import hnsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hnsa_coefs_t coefs,
    input  logic        in_valid,
    output logic        in_ready,
    input  hnsa_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hnsa_xyz_t   out_data
);

    logic signed [PROD_W-1:0] prod_reg [6];
    logic signed [PROD_W-1:0] prod_next [6];
    logic                     a_valid_reg;
    logic                     a_ready;
    hnsa_xyz_t                xyz_reg;
    hnsa_xyz_t                xyz_next;
    logic                     b_valid_reg;
    logic                     b_ready;
    logic signed [PROD_W-1:0] col_s;
    logic signed [PROD_W-1:0] row_s;

    // stage a: six products
    always_comb
    begin
        col_s        = $signed(PROD_W'(in_data.dest_col));
        row_s        = $signed(PROD_W'(in_data.dest_row));
        prod_next[0] = PROD_W'(PROD_W'(coefs.x_per_col) * col_s);
        prod_next[1] = PROD_W'(PROD_W'(coefs.x_per_row) * row_s);
        prod_next[2] = PROD_W'(PROD_W'(coefs.y_per_col) * col_s);
        prod_next[3] = PROD_W'(PROD_W'(coefs.y_per_row) * row_s);
        prod_next[4] = PROD_W'(PROD_W'(coefs.p_per_col) * col_s);
        prod_next[5] = PROD_W'(PROD_W'(coefs.p_per_row) * row_s);
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    // stage b: sums with offsets
    always_comb
    begin
        xyz_next.x = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(coefs.x_offset);
        xyz_next.y = SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]) + SUM_W'(coefs.y_offset);
        xyz_next.z = SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5])
                     + $signed(SUM_W'(ONE_Q32));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            xyz_reg <= xyz_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = xyz_reg;

endmodule

### sv/hnsa_prep.sv
// ----------------------------------------------------------------------------
// hnsa_prep
// Forms the rounding numerators 2x+z, 2y+z and divisor 2z, then sorts each
// coordinate into in-range, rounds-to-zero or outside before the divider.
// ----------------------------------------------------------------------------
module hnsa_prep
    import hnsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hnsa_xyz_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hnsa_div_t out_data
);

    logic signed [N_W-1:0] nc_reg;
    logic signed [N_W-1:0] nr_reg;
    logic signed [N_W-1:0] d_reg;
    logic                  zpos_reg;
    logic                  a_valid_reg;
    logic                  a_ready;
    hnsa_div_t             div_reg;
    hnsa_div_t             div_next;
    logic                  b_valid_reg;
    logic                  b_ready;
    logic [REM_W-1:0]      d_u;
    logic [REM_W-1:0]      nc_mag;
    logic [REM_W-1:0]      nr_mag;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: numerators and divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            nc_reg   <= (N_W'(in_data.x) <<< 1) + N_W'(in_data.z);
            nr_reg   <= (N_W'(in_data.y) <<< 1) + N_W'(in_data.z);
            d_reg    <= N_W'(in_data.z) <<< 1;
            zpos_reg <= (in_data.z > $signed(SUM_W'(0)));
        end
    end

    // stage b: classify each coordinate
    always_comb
    begin
        d_u    = REM_W'(unsigned'(d_reg));
        nc_mag = nc_reg[N_W-1] ? REM_W'(unsigned'(-REM_W'(nc_reg)))
                               : REM_W'(unsigned'(nc_reg));
        nr_mag = nr_reg[N_W-1] ? REM_W'(unsigned'(-REM_W'(nr_reg)))
                               : REM_W'(unsigned'(nr_reg));
        div_next.dsor = d_u << (QBITS - 1);
        div_next.q_c  = '0;
        div_next.q_r  = '0;
        // negative numerator smaller than divisor truncates to zero
        if (!zpos_reg)
        begin
            div_next.ok_c  = 1'b0;
            div_next.rem_c = '0;
        end
        else if (nc_reg[N_W-1])
        begin
            div_next.ok_c  = (nc_mag < d_u);
            div_next.rem_c = '0;
        end
        else
        begin
            div_next.ok_c  = (nc_mag < (d_u << QBITS));
            div_next.rem_c = div_next.ok_c ? nc_mag : '0;
        end
        if (!zpos_reg)
        begin
            div_next.ok_r  = 1'b0;
            div_next.rem_r = '0;
        end
        else if (nr_reg[N_W-1])
        begin
            div_next.ok_r  = (nr_mag < d_u);
            div_next.rem_r = '0;
        end
        else
        begin
            div_next.ok_r  = (nr_mag < (d_u << QBITS));
            div_next.rem_r = div_next.ok_r ? nr_mag : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = div_reg;

endmodule

### sv/hnsa_div_step.sv
// ----------------------------------------------------------------------------
// hnsa_div_step
// One registered restoring division step for both coordinates: subtract the
// shifted divisor when it fits, append a quotient bit, halve the divisor.
// ----------------------------------------------------------------------------
module hnsa_div_step
    import hnsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hnsa_div_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hnsa_div_t out_data
);

    hnsa_div_t step_reg;
    hnsa_div_t step_next;
    logic      valid_reg;
    logic      fit_c;
    logic      fit_r;

    // compare and subtract
    always_comb
    begin
        fit_c          = (in_data.rem_c >= in_data.dsor);
        fit_r          = (in_data.rem_r >= in_data.dsor);
        step_next      = in_data;
        step_next.rem_c = fit_c ? in_data.rem_c - in_data.dsor : in_data.rem_c;
        step_next.rem_r = fit_r ? in_data.rem_r - in_data.dsor : in_data.rem_r;
        step_next.q_c  = {in_data.q_c[QBITS-2:0], fit_c};
        step_next.q_r  = {in_data.q_r[QBITS-2:0], fit_r};
        step_next.dsor = in_data.dsor >> 1;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            step_reg <= step_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = step_reg;

endmodule

### sv/hnsa_check.sv
// ----------------------------------------------------------------------------
// hnsa_check
// Frame bounds check on the rounded quotients and the output register.
// ----------------------------------------------------------------------------
module hnsa_check
    import hnsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hnsa_div_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hnsa_out_t out_data
);

    hnsa_out_t res_reg;
    hnsa_out_t res_next;
    logic      valid_reg;
    logic      in_frame;

    // inside test, zero the coordinates when outside
    always_comb
    begin
        in_frame = in_data.ok_c && in_data.ok_r
                   && ((QBITS + 1)'(in_data.q_c) < (QBITS + 1)'(SRC_WIDTH))
                   && ((QBITS + 1)'(in_data.q_r) < (QBITS + 1)'(SRC_HEIGHT));
        res_next.inside_res = in_frame;
        res_next.src_col    = in_frame ? in_data.q_c[PIX_W-1:0] : '0;
        res_next.src_row    = in_frame ? in_data.q_r[PIX_W-1:0] : '0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

### sv/homography_nearest_source_address_core.sv
// ----------------------------------------------------------------------------
// homography_nearest_source_address_core
// Maps each destination pixel through a homography and gives the nearest
// source pixel address with an inside-frame flag.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one destination pixel per
//   beat; out channel (out_valid/out_ready/out_data) returns one source
//   address beat per input beat, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the eight
//   Q16.32 coefficients; cfg_ready is always high, indexes past seven are
//   dropped. Write coefficients only while no pixel is in flight.
//   The pipeline has two multiply/sum stages, two numerator/classify stages,
//   one restoring division step per quotient bit, and the bounds check
//   register. Throughput is one pixel per cycle while the receiver keeps
//   out_ready high; the per-bit division stages set the depth. Every stage
//   has its own valid bit and takes a new beat whenever it is empty or its
//   contents move on, so bubbles collapse and a stalled receiver only holds
//   the stages behind the output register.
//   Reset clears all valid bits and loads the identity mapping.
// ----------------------------------------------------------------------------
module homography_nearest_source_address_core
    import hnsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hnsa_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hnsa_out_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    hnsa_coefs_t coefs_reg;
    hnsa_xyz_t   xyz;
    logic        xyz_valid;
    logic        xyz_ready;
    hnsa_div_t   div_data  [QBITS+1];
    logic        div_valid [QBITS+1];
    logic        div_ready [QBITS+1];

    // coefficient registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= '{x_per_col: ONE_Q32, y_per_row: ONE_Q32, default: '0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_PER_COL: coefs_reg.x_per_col <= cfg_data;
                REG_X_PER_ROW: coefs_reg.x_per_row <= cfg_data;
                REG_X_OFFSET:  coefs_reg.x_offset  <= cfg_data;
                REG_Y_PER_COL: coefs_reg.y_per_col <= cfg_data;
                REG_Y_PER_ROW: coefs_reg.y_per_row <= cfg_data;
                REG_Y_OFFSET:  coefs_reg.y_offset  <= cfg_data;
                REG_P_PER_COL: coefs_reg.p_per_col <= cfg_data;
                REG_P_PER_ROW: coefs_reg.p_per_row <= cfg_data;
                default:       coefs_reg           <= coefs_reg;
            endcase
        end
    end

    // projection
    hnsa_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .coefs     (coefs_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (xyz_valid),
        .out_ready (xyz_ready),
        .out_data  (xyz)
    );

    // rounding numerators and classification
    hnsa_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xyz_valid),
        .in_ready  (xyz_ready),
        .in_data   (xyz),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // one division step per quotient bit
    for (genvar i = 0; i < QBITS; i++)
    begin : g_div
        hnsa_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // bounds check and output register
    hnsa_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[QBITS]),
        .in_ready  (div_ready[QBITS]),
        .in_data   (div_data[QBITS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
